// ----- sv/fixed_vertex_matrix_transform_unit_assert.svh -----
// Assertion macros shared by the transform unit modules.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef FIXED_VERTEX_MATRIX_TRANSFORM_UNIT_ASSERT_SVH
`define FIXED_VERTEX_MATRIX_TRANSFORM_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define FVM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

`define FVM_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`else

`define FVM_ASSERT(lbl, prop, msg)

`define FVM_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

// ----- sv/fvm_pkg.sv -----
package fvm_pkg;

  // Default number of fraction bits of the fixed-point format.
  localparam int unsigned FVM_FRAC_BITS = 16;

  // Number of vector components and so of lanes.
  localparam int unsigned FVM_DIM = 4;

  // Item kinds.
  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_VERTEX = 1'b1;

  // Input word.
  typedef struct packed {
    logic              kind;
    logic [3:0]        entry_index;
    logic signed [31:0] entry_value;
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] in_z;
    logic signed [31:0] in_w;
  } fvm_in_t;

  // Result word.
  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic signed [31:0] out_w;
  } fvm_out_t;

  // Control carried alongside the product stage.
  typedef struct packed {
    logic valid;
    logic vec3;
  } fvm_ctrl_t;

endpackage

// ----- sv/fvm_matrix.sv -----
module fvm_matrix #(
  parameter int unsigned FRAC_BITS = fvm_pkg::FVM_FRAC_BITS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                we_i,
  input  logic [3:0]          idx_i,
  input  logic [31:0]         val_i,
  output logic [3:0][3:0][31:0] rows_o
);
  import fvm_pkg::*;

  `include "fixed_vertex_matrix_transform_unit_assert.svh"

  localparam logic [31:0] One = 32'd1 << FRAC_BITS;

  logic [31:0] m_q [16];

  // Matrix store: identity after reset, one entry written per load word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 16; k++) begin
        m_q[k] <= ((k % 5) == 0) ? One : 32'd0;
      end
    end else if (we_i) begin
      m_q[idx_i] <= val_i;
    end
  end

  // Each lane sees its own row at a fixed place.
  always_comb begin
    for (int c = 0; c < FVM_DIM; c++) begin
      for (int i = 0; i < FVM_DIM; i++) begin
        rows_o[c][i] = m_q[c * 4 + i];
      end
    end
  end

  `FVM_ASSERT(a_entry_written, we_i |=> m_q[$past(idx_i)] == $past(val_i), "matrix entry not written")

endmodule

// ----- sv/fvm_lane.sv -----
module fvm_lane #(
  parameter int unsigned FRAC_BITS = fvm_pkg::FVM_FRAC_BITS
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic             vec3_i,
  input  logic [3:0][31:0] vtx_i,
  input  logic [3:0][31:0] row_i,
  output logic [31:0]      sum_o
);
  import fvm_pkg::*;

  logic signed [63:0] full [FVM_DIM];
  logic [31:0]        prod_d [FVM_DIM];
  logic [31:0]        prod_q [FVM_DIM];

  // Products, scaled back to the fixed-point format and cut to 32 bits.
  // In vec3 mode the translation entry passes through unscaled.
  always_comb begin
    for (int i = 0; i < FVM_DIM; i++) begin
      full[i]   = $signed(vtx_i[i]) * $signed(row_i[i]);
      prod_d[i] = full[i][FRAC_BITS +: 32];
    end
    if (vec3_i) begin
      prod_d[FVM_DIM - 1] = row_i[FVM_DIM - 1];
    end
  end

  // Product register.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  // Wrapping sum of the four terms.
  assign sum_o = (prod_q[0] + prod_q[1]) + (prod_q[2] + prod_q[3]);

endmodule

// ----- sv/fvm_merge.sv -----
module fvm_merge #(
  parameter int unsigned FRAC_BITS = fvm_pkg::FVM_FRAC_BITS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fvm_pkg::fvm_ctrl_t  ctrl_i,
  input  logic [3:0][31:0]    sums_i,
  output logic                take_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output fvm_pkg::fvm_out_t   out_data_o
);
  import fvm_pkg::*;

  `include "fixed_vertex_matrix_transform_unit_assert.svh"

  localparam logic [31:0] One = 32'd1 << FRAC_BITS;

  logic     out_valid_q, out_valid_d;
  logic     vec3_q;
  fvm_out_t out_q, out_d;
  logic     load;

  // The output register takes a new word when empty or being drained.
  assign take_o = !out_valid_q || out_ready_i;
  assign load   = ctrl_i.valid && take_o;

  // Gather the lanes; w is fixed at one in vec3 mode.
  always_comb begin
    out_d.out_x = sums_i[0];
    out_d.out_y = sums_i[1];
    out_d.out_z = sums_i[2];
    out_d.out_w = ctrl_i.vec3 ? One : sums_i[3];
  end

  always_comb begin
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q  <= out_d;
      vec3_q <= ctrl_i.vec3;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `FVM_ASSERT(a_vec3_w_one, out_valid_q && vec3_q |-> out_q.out_w == One, "vec3 w is not one")

endmodule

// ----- sv/fixed_vertex_matrix_transform_unit.sv -----
// A vertex word goes through the product register and then the result register.
// Throughput: one word per cycle unless the output stalls; the 16 lane multipliers and
// the result register set it. Load words give no result; the matrix is updated at the
// accepting edge. Reset (rst_ni, asynchronous, active low) empties the pipeline, loads
// the identity matrix and clears vec3_mode.
module fixed_vertex_matrix_transform_unit #(
  parameter int unsigned FRAC_BITS = fvm_pkg::FVM_FRAC_BITS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  fvm_pkg::fvm_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output fvm_pkg::fvm_out_t out_data_o
);
  import fvm_pkg::*;

  `include "fixed_vertex_matrix_transform_unit_assert.svh"

  logic                 vec3_mode_q;
  fvm_ctrl_t            s1_q, s1_d;
  logic                 s1_take;
  logic                 in_acc, vtx_acc, load_acc;
  logic [3:0][3:0][31:0] rows;
  logic [3:0][31:0]     vtx;
  logic [3:0][31:0]     sums;

  assign in_ready_o = !s1_q.valid || s1_take;
  assign in_acc     = in_valid_i && in_ready_o;
  assign vtx_acc    = in_acc && (in_data_i.kind == KIND_VERTEX);
  assign load_acc   = in_acc && (in_data_i.kind == KIND_LOAD);

  assign vtx = {in_data_i.in_w, in_data_i.in_z, in_data_i.in_y, in_data_i.in_x};

  // Mode register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vec3_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      vec3_mode_q <= cfg_wdata_i;
    end
  end

  // Product stage control.
  always_comb begin
    s1_d = s1_q;
    if (vtx_acc) begin
      s1_d.valid = 1'b1;
      s1_d.vec3  = vec3_mode_q;
    end else if (s1_take) begin
      s1_d.valid = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
    end else begin
      s1_q <= s1_d;
    end
  end

  fvm_matrix #(
    .FRAC_BITS (FRAC_BITS)
  ) u_matrix (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (load_acc),
    .idx_i  (in_data_i.entry_index),
    .val_i  (in_data_i.entry_value),
    .rows_o (rows)
  );

  // One lane per output component.
  for (genvar c = 0; c < FVM_DIM; c++) begin : g_lane
    fvm_lane #(
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk_i  (clk_i),
      .en_i   (vtx_acc),
      .vec3_i (vec3_mode_q),
      .vtx_i  (vtx),
      .row_i  (rows[c]),
      .sum_o  (sums[c])
    );
  end

  fvm_merge #(
    .FRAC_BITS (FRAC_BITS)
  ) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (s1_q),
    .sums_i      (sums),
    .take_o      (s1_take),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  `FVM_ASSERT(a_load_no_result, load_acc |=> !s1_q.valid, "load word entered the pipeline")
  `FVM_ASSERT(a_vertex_enters, vtx_acc |=> s1_q.valid, "vertex word lost")
  `FVM_ASSERT_NEVER(a_stall_reason, !in_ready_o && !s1_q.valid, "input stalled with empty stage")

endmodule
